// ----- sv/ps2md_pkg.sv -----
`default_nettype none

package ps2md_pkg;

    // Cursor coordinate width; the register and result fields stay 12 bits.
    localparam int COORD_BITS = 12;
    localparam int REG_W      = 12;
    localparam int POS_W      = 12;
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int WIDE_W     = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

    typedef logic [COORD_BITS-1:0]    coord_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam coord_t COORD_MASK = '1;

    localparam logic [REG_W-1:0] MAX_X_RST  = 12'd1023;
    localparam logic [REG_W-1:0] MAX_Y_RST  = 12'd767;
    localparam logic [REG_W-1:0] HOME_X_RST = 12'd400;
    localparam logic [REG_W-1:0] HOME_Y_RST = 12'd300;

    typedef enum logic [2:0] {
        REG_FOUR_BYTE = 3'd0,
        REG_MAX_X     = 3'd1,
        REG_MAX_Y     = 3'd2,
        REG_HOME_X    = 3'd3,
        REG_HOME_Y    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_DOWN   = 2'd1,
        EV_UP     = 2'd2,
        EV_SCROLL = 2'd3
    } evt_kind_t;

    typedef struct packed {
        logic             four_byte;
        logic [REG_W-1:0] max_x;
        logic [REG_W-1:0] max_y;
        logic             home_x_load;
        logic             home_y_load;
        coord_t           home_value;
    } cfg_t;

    // One decoded packet: a mask of pending events plus shared payload.
    typedef struct packed {
        logic [3:0]        mask;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic [2:0]        buttons;
        logic [2:0]        pressed;
        logic [2:0]        released;
        logic signed [4:0] scroll;
    } pkt_rec_t;

    function automatic coord_t clamp_axis(input sum_t v, input logic [REG_W-1:0] maxreg);
        logic [WIDE_W-1:0] mx;
        coord_t            lim;
        coord_t            res;
        mx = WIDE_W'(maxreg);
        if (mx < WIDE_W'(COORD_MASK))
            lim = coord_t'(mx);
        else
            lim = COORD_MASK;
        if (v < 0)
            res = '0;
        else if (v > $signed({2'b00, lim}))
            res = lim;
        else
            res = coord_t'(v);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ps2_mouse_packet_decoder.sv -----
`default_nettype none

// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// byte     | byte_valid / byte_stall | data_byte
// event    | event_valid/event_stall | event_kind, pos_x, pos_y, move_dx, move_dy,
//          |                         | button_state, changed_buttons,
//          |                         | scroll_amount, last_event
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One mouse byte is taken per cycle while byte_stall is low. A byte is held in
// the input register until its events are loaded into the result register.
// The final byte of a packet can raise up to four events; the result register
// sends one per cycle unless event_stall is high, so such a byte holds the
// input side until its last event is sent. rst_n clears position and buttons,
// restores the config defaults and loads the home cursor. A stalled event holds
// the result register and backs up byte_stall.
module ps2_mouse_packet_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        byte_valid,
    output logic                             byte_stall,
    input  wire logic [7:0]                  data_byte,

    output logic                             event_valid,
    input  wire logic                        event_stall,
    output logic [1:0]                       event_kind,
    output logic [ps2md_pkg::POS_W-1:0]      pos_x,
    output logic [ps2md_pkg::POS_W-1:0]      pos_y,
    output logic signed [8:0]                move_dx,
    output logic signed [9:0]                move_dy,
    output logic [2:0]                       button_state,
    output logic [2:0]                       changed_buttons,
    output logic signed [4:0]                scroll_amount,
    output logic                             last_event,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [ps2md_pkg::REG_W-1:0] cfg_data
);

    ps2md_pkg::cfg_t      cfg;
    ps2md_pkg::pkt_rec_t  rec;
    logic                 rec_valid;
    logic                 take;

    // Config registers; home writes pulse a cursor load.
    ps2md_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, packet gathering, cursor and button state.
    ps2md_assembler u_asm (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .cfg        (cfg),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .take       (take)
    );

    // Result register: walk pending events in order move, down, up, scroll.
    ps2md_emitter u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_valid       (rec_valid),
        .rec             (rec),
        .take            (take),
        .event_valid     (event_valid),
        .event_stall     (event_stall),
        .event_kind      (event_kind),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .move_dx         (move_dx),
        .move_dy         (move_dy),
        .button_state    (button_state),
        .changed_buttons (changed_buttons),
        .scroll_amount   (scroll_amount),
        .last_event      (last_event)
    );

endmodule

`default_nettype wire

// ----- sv/ps2md_cfg_regs.sv -----
`default_nettype none

module ps2md_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [ps2md_pkg::REG_W-1:0]  cfg_data,
    output ps2md_pkg::cfg_t                   cfg
);

    logic                         four_byte_reg;
    logic                         four_byte_next;
    logic [ps2md_pkg::REG_W-1:0]  max_x_reg;
    logic [ps2md_pkg::REG_W-1:0]  max_x_next;
    logic [ps2md_pkg::REG_W-1:0]  max_y_reg;
    logic [ps2md_pkg::REG_W-1:0]  max_y_next;
    logic                         wr;
    logic                         load_x;
    logic                         load_y;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_comb
    begin
        four_byte_next = four_byte_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        load_x         = 1'b0;
        load_y         = 1'b0;
        if (wr)
        begin
            case (cfg_index)
                ps2md_pkg::REG_FOUR_BYTE: four_byte_next = cfg_data[0];
                ps2md_pkg::REG_MAX_X:     max_x_next     = cfg_data;
                ps2md_pkg::REG_MAX_Y:     max_y_next     = cfg_data;
                ps2md_pkg::REG_HOME_X:    load_x         = 1'b1;
                ps2md_pkg::REG_HOME_Y:    load_y         = 1'b1;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_byte_reg <= 1'b0;
            max_x_reg     <= ps2md_pkg::MAX_X_RST;
            max_y_reg     <= ps2md_pkg::MAX_Y_RST;
        end
        else
        begin
            four_byte_reg <= four_byte_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
        end
    end

    // Home writes go straight to the cursor; the value is not kept here.
    assign cfg.four_byte   = four_byte_reg;
    assign cfg.max_x       = max_x_reg;
    assign cfg.max_y       = max_y_reg;
    assign cfg.home_x_load = load_x;
    assign cfg.home_y_load = load_y;
    assign cfg.home_value  = ps2md_pkg::coord_t'(cfg_data);

endmodule

`default_nettype wire

// ----- sv/ps2md_assembler.sv -----
`default_nettype none

module ps2md_assembler (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire logic [7:0]        data_byte,
    input  wire ps2md_pkg::cfg_t   cfg,
    output logic                   rec_valid,
    output ps2md_pkg::pkt_rec_t    rec,
    input  wire logic              take
);

    logic                  byte_valid_reg;
    logic                  byte_valid_next;
    logic [7:0]            byte_reg;
    logic [1:0]            pos_reg;
    logic [1:0]            pos_next;
    logic [7:0]            held_reg [0:2];
    ps2md_pkg::coord_t     cur_x_reg;
    ps2md_pkg::coord_t     cur_x_next;
    ps2md_pkg::coord_t     cur_y_reg;
    ps2md_pkg::coord_t     cur_y_next;
    logic [2:0]            btn_reg;
    logic [2:0]            btn_next;

    logic                  step;
    logic                  accept;
    logic                  bad_first;
    logic                  complete;
    logic                  store;
    logic                  pkt_ok;
    logic [7:0]            flags;
    logic [7:0]            p1;
    logic [7:0]            p2;
    logic [7:0]            p3;
    logic signed [8:0]     dx;
    logic signed [8:0]     dy9;
    logic signed [9:0]     dy10;
    ps2md_pkg::sum_t       sum_x;
    ps2md_pkg::sum_t       sum_y;
    ps2md_pkg::coord_t     new_x;
    ps2md_pkg::coord_t     new_y;
    logic [2:0]            nb;
    logic [2:0]            pressed;
    logic [2:0]            released;
    logic signed [3:0]     wheel;

    assign byte_stall = byte_valid_reg & ~take;
    assign accept     = byte_valid & ~byte_stall;
    assign step       = byte_valid_reg & take;
    assign rec_valid  = byte_valid_reg;

    assign bad_first = (pos_reg == 2'd0) & ~byte_reg[3];
    assign complete  = cfg.four_byte ? (pos_reg == 2'd3) : pos_reg[1];
    assign store     = ~bad_first & ~complete;

    // Assemble the packet from held bytes and the byte now in hand.
    assign flags = held_reg[0];
    assign p1    = held_reg[1];
    assign p2    = (pos_reg == 2'd2) ? byte_reg : held_reg[2];
    assign p3    = byte_reg;

    assign pkt_ok = complete & flags[3] & ~flags[7] & ~flags[6];

    assign dx    = $signed({flags[4], p1});
    assign dy9   = $signed({flags[5], p2});
    assign dy10  = 10'(dy9);
    assign sum_x = ps2md_pkg::sum_t'($signed({2'b00, cur_x_reg})) + ps2md_pkg::sum_t'(dx);
    assign sum_y = ps2md_pkg::sum_t'($signed({2'b00, cur_y_reg})) - ps2md_pkg::sum_t'(dy9);
    assign new_x = ps2md_pkg::clamp_axis(sum_x, cfg.max_x);
    assign new_y = ps2md_pkg::clamp_axis(sum_y, cfg.max_y);

    assign nb       = flags[2:0];
    assign pressed  = nb & ~btn_reg;
    assign released = btn_reg & ~nb;
    assign wheel    = $signed(p3[3:0]);

    always_comb
    begin
        rec.mask[ps2md_pkg::EV_MOVE]   = pkt_ok & ((dx != 9'sd0) | (dy9 != 9'sd0));
        rec.mask[ps2md_pkg::EV_DOWN]   = pkt_ok & (pressed != 3'd0);
        rec.mask[ps2md_pkg::EV_UP]     = pkt_ok & (released != 3'd0);
        rec.mask[ps2md_pkg::EV_SCROLL] = pkt_ok & cfg.four_byte & (wheel != 4'sd0);
        rec.pos_x    = ps2md_pkg::POS_W'(new_x);
        rec.pos_y    = ps2md_pkg::POS_W'(new_y);
        rec.dx       = dx;
        rec.dy       = -dy10;
        rec.buttons  = nb;
        rec.pressed  = pressed;
        rec.released = released;
        rec.scroll   = -(5'(wheel));
    end

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (accept)
            byte_valid_next = 1'b1;
        else if (take)
            byte_valid_next = 1'b0;

        pos_next   = pos_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        btn_next   = btn_reg;
        if (step && !bad_first)
        begin
            if (store)
                pos_next = pos_reg + 2'd1;
            else
            begin
                pos_next = 2'd0;
                if (pkt_ok)
                begin
                    cur_x_next = new_x;
                    cur_y_next = new_y;
                    btn_next   = nb;
                end
            end
        end
        // Home write loads the cursor unclamped.
        if (cfg.home_x_load)
            cur_x_next = cfg.home_value;
        if (cfg.home_y_load)
            cur_y_next = cfg.home_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            pos_reg        <= 2'd0;
            cur_x_reg      <= ps2md_pkg::coord_t'(ps2md_pkg::HOME_X_RST);
            cur_y_reg      <= ps2md_pkg::coord_t'(ps2md_pkg::HOME_Y_RST);
            btn_reg        <= 3'd0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            pos_reg        <= pos_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            btn_reg        <= btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            byte_reg <= data_byte;
        for (int i = 0; i < 3; i++)
        begin
            if (step && store && (pos_reg == 2'(i)))
                held_reg[i] <= byte_reg;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ps2md_emitter.sv -----
`default_nettype none

module ps2md_emitter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rec_valid,
    input  wire ps2md_pkg::pkt_rec_t         rec,
    output logic                             take,
    output logic                             event_valid,
    input  wire logic                        event_stall,
    output logic [1:0]                       event_kind,
    output logic [ps2md_pkg::POS_W-1:0]      pos_x,
    output logic [ps2md_pkg::POS_W-1:0]      pos_y,
    output logic signed [8:0]                move_dx,
    output logic signed [9:0]                move_dy,
    output logic [2:0]                       button_state,
    output logic [2:0]                       changed_buttons,
    output logic signed [4:0]                scroll_amount,
    output logic                             last_event
);

    logic [3:0]            mask_reg;
    logic [3:0]            mask_next;
    ps2md_pkg::pkt_rec_t   rec_reg;
    logic [3:0]            remaining;
    logic                  xfer;
    ps2md_pkg::evt_kind_t  kind;

    assign event_valid = (mask_reg != 4'd0);
    assign xfer        = event_valid & ~event_stall;
    // Drop the lowest pending event once it is transferred.
    assign remaining   = mask_reg & (mask_reg - 4'd1);
    assign last_event  = (remaining == 4'd0);
    assign take        = ~event_valid | (xfer & last_event);

    always_comb
    begin
        if (mask_reg[ps2md_pkg::EV_MOVE])
            kind = ps2md_pkg::EV_MOVE;
        else if (mask_reg[ps2md_pkg::EV_DOWN])
            kind = ps2md_pkg::EV_DOWN;
        else if (mask_reg[ps2md_pkg::EV_UP])
            kind = ps2md_pkg::EV_UP;
        else
            kind = ps2md_pkg::EV_SCROLL;
    end

    always_comb
    begin
        event_kind      = kind;
        pos_x           = rec_reg.pos_x;
        pos_y           = rec_reg.pos_y;
        button_state    = rec_reg.buttons;
        move_dx         = rec_reg.dx;
        move_dy         = rec_reg.dy;
        changed_buttons = 3'd0;
        scroll_amount   = 5'sd0;
        case (kind)
            ps2md_pkg::EV_DOWN: changed_buttons = rec_reg.pressed;
            ps2md_pkg::EV_UP:   changed_buttons = rec_reg.released;
            ps2md_pkg::EV_SCROLL:
            begin
                move_dx       = 9'sd0;
                move_dy       = 10'sd0;
                scroll_amount = rec_reg.scroll;
            end
            default:            ;
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (take && rec_valid)
            mask_next = rec.mask;
        else if (xfer)
            mask_next = remaining;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= 4'd0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && rec_valid)
            rec_reg <= rec;
    end

endmodule

`default_nettype wire
